>>> rtl/hlic_pkg.sv
`default_nettype none

package hlic_pkg;

   // Correction table geometry: one entry per whole degree.
   localparam int unsigned TABLE_ENTRIES = 360;
   localparam int unsigned IDX_W         = 9;
   localparam int unsigned ENTRY_W       = 16;

   // Angles are fixed point with eight fraction bits (1/256 degree).
   localparam int unsigned FRAC_BITS = 8;

   // Field widths of the request and response items.
   localparam int unsigned HEADING_IN_W  = 18;
   localparam int unsigned HEADING_OUT_W = 17;

   // Last table entry; writing it marks the table as loaded.
   localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(TABLE_ENTRIES - 1);

   // Request action codes.
   localparam logic ACT_APPLY = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   typedef logic [IDX_W-1:0]          idx_type;
   typedef logic signed [ENTRY_W-1:0] entry_type;

   // One write into the correction table.
   typedef struct packed {
      logic      en;
      idx_type   addr;
      entry_type data;
   } tbl_wr_type;

endpackage

`default_nettype wire

>>> rtl/heading_lut_interp_correction_top.sv
`default_nettype none

// Heading correction by a 360-entry circular table with linear interpolation.
// Angles are in 1/256 degree. A write request (action 1) stores one table
// entry and produces no response; writing entry 359 marks the table loaded.
// An apply request (action 0) produces one response, and one request can be
// accepted every cycle while req_stall is low: the table is a memory with
// two read ports that fetches both interpolation entries in the accept
// cycle, followed by a multiply stage and the response register.
// While a response waits on rsp_stall the pipeline keeps accepting requests
// until its two internal stages are full. After reset the table is swept to
// zero one entry per cycle, with req_stall held high meanwhile; the
// enable register can be written during that time.
module heading_lut_interp_correction_top
   import hlic_pkg::*;
(
   input  wire                              clock,
   input  wire                              reset,
   // Request channel.
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire                              req_action,
   input  wire signed [HEADING_IN_W-1:0]    req_heading_in,
   input  wire        [IDX_W-1:0]           req_entry_index,
   input  wire signed [ENTRY_W-1:0]         req_entry_value,
   // Response channel.
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic signed [HEADING_OUT_W-1:0]  rsp_heading_out,
   output logic                             rsp_was_corrected,
   // Enable register.
   input  wire                              csr_wr_en,
   input  wire                              csr_wr_data
);

   localparam int unsigned SUM_W = HEADING_IN_W + 1;
   localparam int unsigned POS_W = HEADING_OUT_W;
   localparam int unsigned DIFF_W = ENTRY_W + 1;
   localparam int unsigned PROD_W = DIFF_W + FRAC_BITS + 1;

   localparam logic signed [SUM_W-1:0] HALF_TURN = SUM_W'(180 * (1 << FRAC_BITS));
   localparam logic signed [SUM_W-1:0] FULL_TURN = SUM_W'(360 * (1 << FRAC_BITS));
   localparam logic signed [SUM_W-1:0] HALF_PLUS_FULL = SUM_W'(540 * (1 << FRAC_BITS));
   localparam logic signed [SUM_W-1:0] TWO_TURNS = SUM_W'(720 * (1 << FRAC_BITS));

   // Bring an angle into [-180,180] degrees by whole turns; ends are kept.
   function automatic logic signed [HEADING_OUT_W-1:0] wrap_half(
      input logic signed [SUM_W-1:0] x
   );
      logic signed [SUM_W-1:0] y;
      begin
         priority if (x > HALF_PLUS_FULL) begin
            y = x - TWO_TURNS;
         end else if (x > HALF_TURN) begin
            y = x - FULL_TURN;
         end else if (x < -HALF_PLUS_FULL) begin
            y = x + TWO_TURNS;
         end else if (x < -HALF_TURN) begin
            y = x + FULL_TURN;
         end else begin
            y = x;
         end
         return y[HEADING_OUT_W-1:0];
      end
   endfunction

   logic csr_enable_ff;
   logic loaded_ff;

   logic s1_valid_ff;
   logic signed [HEADING_IN_W-1:0]  s1_raw_ff;
   logic signed [HEADING_OUT_W-1:0] s1_norm_ff;
   logic [FRAC_BITS-1:0]            s1_frac_ff;
   logic                            s1_active_ff;

   logic s2_valid_ff;
   logic signed [HEADING_IN_W-1:0]  s2_raw_ff;
   logic signed [HEADING_OUT_W-1:0] s2_norm_ff;
   logic                            s2_active_ff;
   entry_type                       s2_c0_ff;
   logic signed [PROD_W-1:0]        s2_prod_ff;

   logic                            rsp_valid_ff;
   logic signed [HEADING_OUT_W-1:0] rsp_heading_out_ff;
   logic                            rsp_was_corrected_ff;

   logic en1, en2, en3;
   logic accept, apply_acc, write_acc;
   logic clr_busy;
   tbl_wr_type tbl_wr;

   logic signed [HEADING_OUT_W-1:0] norm_in;
   logic [POS_W-1:0]                pos_in;
   idx_type                         idx0_in;
   idx_type                         idx1_in;
   entry_type                       c0, c1;
   logic signed [DIFF_W-1:0]        diff_in;
   logic signed [PROD_W-1:0]        prod_in;
   logic signed [SUM_W-1:0]         sum_in;
   logic signed [HEADING_OUT_W-1:0] heading_out_in;

   // Stage enables: a stage moves when it is empty or its successor moves.
   assign en3 = !rsp_valid_ff || !rsp_stall;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;

   assign req_stall = clr_busy || !en1;
   assign accept    = req_valid && !req_stall;
   assign apply_acc = accept && (req_action == ACT_APPLY);
   assign write_acc = accept && (req_action == ACT_WRITE);

   // Enable register and the sticky table-loaded flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_enable_ff <= 1'b0;
         loaded_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            csr_enable_ff <= csr_wr_data;
         end
         if (write_acc && req_entry_index == LAST_ENTRY) begin
            loaded_ff <= 1'b1;
         end
      end
   end

   // Table writes; indexes past the last entry are dropped.
   always_comb begin
      tbl_wr.en   = write_acc && (req_entry_index <= LAST_ENTRY);
      tbl_wr.addr = req_entry_index;
      tbl_wr.data = req_entry_value;
   end

   // Normalize the raw heading and find the two neighboring entries.
   always_comb begin
      norm_in = wrap_half(SUM_W'(req_heading_in));
      if (norm_in < 0) begin
         pos_in = POS_W'(SUM_W'(norm_in) + FULL_TURN);
      end else begin
         pos_in = POS_W'(norm_in);
      end
      idx0_in = pos_in[POS_W-1:FRAC_BITS];
      if (idx0_in == LAST_ENTRY) begin
         idx1_in = '0;
      end else begin
         idx1_in = idx0_in + 1'b1;
      end
   end

   hlic_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (tbl_wr),
      .rd_en    (en1),
      .rd_addr0 (idx0_in),
      .rd_addr1 (idx1_in),
      .rd_data0 (c0),
      .rd_data1 (c1),
      .clr_busy (clr_busy)
   );

   // Stage 1: table read in flight, heading context registered.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= apply_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_raw_ff    <= req_heading_in;
         s1_norm_ff   <= norm_in;
         s1_frac_ff   <= pos_in[FRAC_BITS-1:0];
         s1_active_ff <= csr_enable_ff && loaded_ff;
      end
   end

   // Slope times fraction, exact.
   always_comb begin
      diff_in = DIFF_W'(c1) - DIFF_W'(c0);
      prod_in = PROD_W'(diff_in) * PROD_W'($signed({1'b0, s1_frac_ff}));
   end

   // Stage 2: product registered.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_raw_ff    <= s1_raw_ff;
         s2_norm_ff   <= s1_norm_ff;
         s2_active_ff <= s1_active_ff;
         s2_c0_ff     <= c0;
         s2_prod_ff   <= prod_in;
      end
   end

   // Arithmetic shift floors toward minus infinity; add to the raw heading.
   always_comb begin
      sum_in = SUM_W'(s2_raw_ff) + SUM_W'(s2_c0_ff)
             + SUM_W'(s2_prod_ff >>> FRAC_BITS);
      if (s2_active_ff) begin
         heading_out_in = wrap_half(sum_in);
      end else begin
         heading_out_in = s2_norm_ff;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en3) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         rsp_heading_out_ff   <= heading_out_in;
         rsp_was_corrected_ff <= s2_active_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_heading_out   = rsp_heading_out_ff;
   assign rsp_was_corrected = rsp_was_corrected_ff;

endmodule

`default_nettype wire

>>> rtl/hlic_table.sv
`default_nettype none

module hlic_table
   import hlic_pkg::*;
(
   input  wire             clock,
   input  wire             reset,
   input  wire tbl_wr_type wr,
   input  wire             rd_en,
   input  wire idx_type    rd_addr0,
   input  wire idx_type    rd_addr1,
   output entry_type       rd_data0,
   output entry_type       rd_data1,
   output logic            clr_busy
);

   entry_type mem [0:TABLE_ENTRIES-1];

   logic    clr_busy_ff;
   idx_type clr_addr_ff;
   entry_type rd_data0_ff;
   entry_type rd_data1_ff;

   // After reset, sweep the table once and zero every entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == LAST_ENTRY) begin
            clr_busy_ff <= 1'b0;
         end else begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   // Single write port, shared by the clearing sweep and table writes.
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Two registered read ports; data holds while the consumer is stalled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data0_ff <= mem[rd_addr0];
         rd_data1_ff <= mem[rd_addr1];
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;
   assign clr_busy = clr_busy_ff;

endmodule

`default_nettype wire

>>> tb/heading_correction_check.sv
`timescale 1ns / 100ps

// Watches the request, response and enable ports of the heading corrector.
// It keeps its own copy of the correction table, predicts the response of
// every accepted apply request and compares it with what comes out.
module heading_correction_check
   import hlic_pkg::*;
(
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   input  wire                             req_stall,
   input  wire                             req_action,
   input  wire signed [HEADING_IN_W-1:0]   req_heading_in,
   input  wire        [IDX_W-1:0]          req_entry_index,
   input  wire signed [ENTRY_W-1:0]        req_entry_value,
   input  wire                             rsp_valid,
   input  wire                             rsp_stall,
   input  wire signed [HEADING_OUT_W-1:0]  rsp_heading_out,
   input  wire                             rsp_was_corrected,
   input  wire                             csr_wr_en,
   input  wire                             csr_wr_data,
   output int                              fail_count,
   output int                              pending
);

   localparam longint ONE_DEGREE = longint'(1) << FRAC_BITS;
   localparam longint HALF_TURN  = 180 * ONE_DEGREE;
   localparam longint FULL_TURN  = 360 * ONE_DEGREE;

   typedef struct packed {
      logic signed [HEADING_OUT_W-1:0] heading;
      logic                            corrected;
   } heading_result_type;

   // Shadow copy of the block's state.
   logic signed [ENTRY_W-1:0] corr_table [TABLE_ENTRIES];
   logic                      table_loaded;
   logic                      corr_enable;

   heading_result_type expected_headings [$];

   // Brings an angle into [-180,180] degrees by a whole number of turns.
   function automatic longint wrap_turns(input longint angle);
      longint turns;
      if (angle > HALF_TURN) begin
         turns = (angle - HALF_TURN + FULL_TURN - 1) / FULL_TURN;
         angle = angle - turns * FULL_TURN;
      end else if (angle < -HALF_TURN) begin
         turns = (-HALF_TURN - angle + FULL_TURN - 1) / FULL_TURN;
         angle = angle + turns * FULL_TURN;
      end
      return angle;
   endfunction

   // Normalizes a raw heading and, when active, adds the interpolated
   // table correction to the raw value before normalizing again.
   function automatic heading_result_type correct_heading(input longint raw);
      heading_result_type res;
      longint          norm;
      longint          pos;
      longint          frac;
      longint          c0;
      longint          c1;
      longint          sum;
      int              i0;
      int              i1;
      norm          = wrap_turns(raw);
      res.corrected = corr_enable && table_loaded;
      res.heading   = norm[HEADING_OUT_W-1:0];
      if (res.corrected) begin
         pos  = (norm < 0) ? norm + FULL_TURN : norm;
         i0   = int'(pos >> FRAC_BITS);
         frac = pos[FRAC_BITS-1:0];
         // The entry after the last degree wraps around to entry zero.
         i1   = (i0 == TABLE_ENTRIES - 1) ? 0 : i0 + 1;
         c0   = corr_table[i0];
         c1   = corr_table[i1];
         // The arithmetic shift rounds the interpolation toward minus infinity.
         sum  = wrap_turns(raw + c0 + (((c1 - c0) * frac) >>> FRAC_BITS));
         res.heading = sum[HEADING_OUT_W-1:0];
      end
      return res;
   endfunction

   // Track the state, queue predictions and check responses at each edge.
   always @(posedge clock) begin
      heading_result_type want;
      if (reset) begin
         foreach (corr_table[i]) begin
            corr_table[i] = '0;
         end
         table_loaded = 1'b0;
         corr_enable  = 1'b0;
         fail_count   = 0;
         expected_headings.delete();
      end else begin
         if (req_valid && !req_stall) begin
            if (req_action == ACT_WRITE) begin
               // Writes beyond the last entry are dropped.
               if (req_entry_index < TABLE_ENTRIES) begin
                  corr_table[req_entry_index] = req_entry_value;
                  if (req_entry_index == LAST_ENTRY) begin
                     table_loaded = 1'b1;
                  end
               end
            end else begin
               expected_headings.push_back(correct_heading(req_heading_in));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_headings.size() == 0) begin
               $error("response with no request outstanding: heading_out %0d",
                      rsp_heading_out);
               fail_count++;
            end else begin
               want = expected_headings.pop_front();
               if (rsp_heading_out !== want.heading) begin
                  $error("heading_out mismatch: expected %0d, actual %0d",
                         want.heading, rsp_heading_out);
                  fail_count++;
               end
               if (rsp_was_corrected !== want.corrected) begin
                  $error("was_corrected mismatch: expected %0b, actual %0b",
                         want.corrected, rsp_was_corrected);
                  fail_count++;
               end
            end
         end
         if (csr_wr_en) begin
            corr_enable = csr_wr_data;
         end
      end
      pending = expected_headings.size();
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import hlic_pkg::*;

   localparam int HOLD_CYCLES  = 64;
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 135;
   localparam int HALF_TURN    = 46080;
   localparam int FULL_TURN    = 92160;
   localparam int LIMIT_NS     = 5_000_000;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic                             req_action = ACT_APPLY;
   logic signed [HEADING_IN_W-1:0]   req_heading_in = '0;
   logic        [IDX_W-1:0]          req_entry_index = '0;
   logic signed [ENTRY_W-1:0]        req_entry_value = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic signed [HEADING_OUT_W-1:0]  rsp_heading_out;
   logic                             rsp_was_corrected;
   logic                             csr_wr_en = 1'b0;
   logic                             csr_wr_data = 1'b0;

   int fail_count;
   int pending;
   int send_idle_pct = 0;
   int rcv_stall_pct = 0;
   int hold_requests = 0;
   int holds_done    = 0;

   always #5 clock = ~clock;

   heading_lut_interp_correction_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_heading_in    (req_heading_in),
      .req_entry_index   (req_entry_index),
      .req_entry_value   (req_entry_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_heading_out   (rsp_heading_out),
      .rsp_was_corrected (rsp_was_corrected),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   heading_correction_check u_heading_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_heading_in    (req_heading_in),
      .req_entry_index   (req_entry_index),
      .req_entry_value   (req_entry_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_heading_out   (rsp_heading_out),
      .rsp_was_corrected (rsp_was_corrected),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   // Offers one request after a random gap and holds it until it is taken.
   // Called and returning at a falling edge.
   task automatic send_request(input logic act, input int heading,
                               input logic [IDX_W-1:0] index,
                               input logic [ENTRY_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_heading_in  <= heading[HEADING_IN_W-1:0];
      req_entry_index <= index;
      req_entry_value <= value;
      do begin
         @(posedge clock);
      end while (req_stall);
      @(negedge clock);
   endtask

   task automatic apply_heading(input int heading);
      send_request(ACT_APPLY, heading, IDX_W'($urandom), ENTRY_W'($urandom));
   endtask

   task automatic write_entry(input logic [IDX_W-1:0] index, input int value);
      send_request(ACT_WRITE, int'($urandom), index, value[ENTRY_W-1:0]);
   endtask

   // Waits until every response has come out, then lets the pipeline settle,
   // since table writes in flight produce no response.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_enable(input logic enable);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= enable;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly apply requests spread over the legal range, near the wrap points
   // and over the whole field, mixed with table rewrites.
   task automatic send_random_item();
      int pick;
      int heading;
      pick = $urandom_range(99);
      if (pick < 20) begin
         if ($urandom_range(9) == 0) begin
            write_entry(IDX_W'($urandom), int'($urandom));
         end else begin
            write_entry(IDX_W'($urandom_range(TABLE_ENTRIES - 1)), int'($urandom));
         end
      end else begin
         pick = $urandom_range(9);
         if (pick < 6) begin
            heading = int'($urandom_range(2 * FULL_TURN)) - FULL_TURN;
         end else if (pick < 8) begin
            case ($urandom_range(4))
               0: heading = 0;
               1: heading = HALF_TURN;
               2: heading = -HALF_TURN;
               3: heading = FULL_TURN;
               default: heading = -FULL_TURN;
            endcase
            heading = heading + int'($urandom_range(6)) - 3;
         end else begin
            heading = int'($urandom);
         end
         apply_heading(heading);
      end
   endtask

   // Response side: random stalls, plus a long hold-off whenever one is asked.
   initial begin
      forever begin
         @(negedge clock);
         if (holds_done != hold_requests) begin
            holds_done++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
      end
   end

   // Run limit.
   initial begin
      #(LIMIT_NS);
      $display("tb_top NOT OK");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Normalization only: correction off and table not loaded.
      apply_heading(0);
      apply_heading(HALF_TURN + 1);
      apply_heading(-131072);

      // Correction requested, but the table is still not loaded.
      write_enable(1'b1);
      apply_heading(HALF_TURN);
      apply_heading(-HALF_TURN);
      apply_heading(FULL_TURN);
      apply_heading(131071);

      // Extreme entries, dropped out-of-range writes, then the last entry.
      write_entry(IDX_W'(0), 32767);
      write_entry(IDX_W'(1), -32768);
      write_entry(IDX_W'(511), 5);
      write_entry(IDX_W'(TABLE_ENTRIES), 7);
      write_entry(LAST_ENTRY, -1000);

      // Interpolation across the extremes and across the wrap to entry zero.
      apply_heading(0);
      apply_heading(128);
      apply_heading(-1);
      apply_heading(255);
      apply_heading(-FULL_TURN);
      apply_heading(-131072);
      apply_heading(HALF_TURN + 1);
      apply_heading(HALF_TURN);

      // Random phases with different enable settings and idle patterns.
      for (int p = 0; p < PHASES; p++) begin
         write_enable((p % 3) != 1);
         send_idle_pct = (p % 4 == 1) ? 54 : (p % 4 == 3) ? 36 : 0;
         rcv_stall_pct = (p % 4 == 2) ? 54 : (p % 4 == 3) ? 36 : 0;
         if (p == 0) begin
            hold_requests++;
         end
         repeat (PHASE_ITEMS) send_random_item();
      end

      wait_drained();
      if (fail_count == 0 && pending == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/hlic_pkg.sv
rtl/hlic_table.sv
rtl/heading_lut_interp_correction_top.sv
tb/heading_correction_check.sv
tb/tb_top.sv
